// ===== rtl/bprd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bprd_pkg;

    // field widths
    localparam int unsigned PAIR_W        = 13;
    localparam int unsigned VALUE_W       = 2;
    localparam int unsigned TILES_W       = 4;
    localparam int unsigned TILE_SHIFT    = 5;   // 32 pairs per tile of one plane
    localparam int unsigned PROD_W        = 2 * TILES_W;
    localparam int unsigned CFG_IDX_W     = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES = 1'd1;

    localparam int unsigned MAX_PREFIX_BITS_DEF = 16;

    // decoder phase
    typedef enum logic [2:0] {
        PH_WAIT       = 3'd0,
        PH_DATA_HI    = 3'd1,
        PH_DATA_LO    = 3'd2,
        PH_RLE_PREFIX = 3'd3,
        PH_RLE_VALUE  = 3'd4
    } phase_t;

    // one decoded run
    typedef struct packed {
        logic [PAIR_W-1:0]  start_pair;
        logic [PAIR_W-1:0]  run_length;
        logic [VALUE_W-1:0] pair_value;
        logic               overrun;
        logic               plane_done;
    } run_t;

endpackage

`default_nettype wire

// ===== rtl/bitplane_rle_pair_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bitplane pair-run decoder. Takes the compressed stream one bit per beat and
// gives one beat per decoded run (start pair, length, value, overrun and
// plane-done flags); the consumer maps pairs to bytes and ORs them in. Rate is
// one input bit per clock: every bit is decoded in the cycle it is accepted
// and the run lands in a result register backed by a one-entry skid register,
// so input stalls only when both of those are full. width_tiles and
// height_tiles reset to 1; the user must write them through the cfg port
// while idle, as the block itself does not enforce it.
module bitplane_rle_pair_decoder #(
    parameter int unsigned MAX_PREFIX_BITS = bprd_pkg::MAX_PREFIX_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [bprd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bprd_pkg::TILES_W-1:0]     cfg_data,
    // compressed bit stream
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             stream_bit,
    // decoded runs
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bprd_pkg::PAIR_W-1:0]           start_pair,
    output logic [bprd_pkg::PAIR_W-1:0]           run_length,
    output logic [bprd_pkg::VALUE_W-1:0]          pair_value,
    output logic                                  overrun,
    output logic                                  plane_done
);
    import bprd_pkg::*;

    localparam int unsigned PV_W  = MAX_PREFIX_BITS;
    localparam int unsigned PB_W  = $clog2(MAX_PREFIX_BITS + 1);
    localparam int unsigned TOT_W = (MAX_PREFIX_BITS + 1 > PAIR_W) ?
                                    MAX_PREFIX_BITS + 1 : PAIR_W;

    // configuration registers
    logic [TILES_W-1:0] width_tiles_reg;
    logic [TILES_W-1:0] height_tiles_reg;

    // decoder state
    phase_t            phase_reg, phase_next;
    logic              held_bit_reg, held_bit_next;
    logic [PV_W-1:0]   prefix_value_reg, prefix_value_next;
    logic [PB_W-1:0]   prefix_bits_reg, prefix_bits_next;
    logic [PV_W-1:0]   run_value_reg, run_value_next;
    logic [PB_W-1:0]   value_bits_left_reg, value_bits_left_next;
    logic [PAIR_W-1:0] pairs_written_reg, pairs_written_next;

    // result and skid registers
    logic              out_valid_reg;
    run_t              out_reg;
    logic              skid_valid_reg;
    run_t              skid_reg;

    logic              fire;
    logic              res_valid;
    run_t              res;
    logic              take;

    logic [PROD_W-1:0] tile_count;
    logic [PAIR_W-1:0] plane_size;
    logic [PAIR_W-1:0] pairs_left;
    logic [1:0]        pair;
    logic [PB_W-1:0]   prefix_bits_inc;
    logic [PV_W-1:0]   run_value_shift;
    logic [PB_W-1:0]   value_bits_dec;
    logic [TOT_W-1:0]  total;
    logic [PAIR_W-1:0] len;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_tiles_reg  <= TILES_W'(1);
            height_tiles_reg <= TILES_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH_TILES:  width_tiles_reg  <= cfg_data;
                REG_HEIGHT_TILES: height_tiles_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // plane geometry
    assign tile_count = width_tiles_reg * height_tiles_reg;
    assign plane_size = PAIR_W'({tile_count, {TILE_SHIFT{1'b0}}});
    assign pairs_left = (plane_size > pairs_written_reg) ?
                        plane_size - pairs_written_reg : '0;

    assign in_ready = !skid_valid_reg;
    assign fire     = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    assign pair            = {held_bit_reg, stream_bit};
    assign prefix_bits_inc = prefix_bits_reg + PB_W'(1);
    assign run_value_shift = {run_value_reg[PV_W-2:0], stream_bit};
    assign value_bits_dec  = (value_bits_left_reg != '0) ?
                             value_bits_left_reg - PB_W'(1) : '0;
    assign total           = TOT_W'(prefix_value_reg) + TOT_W'(1) +
                             TOT_W'(run_value_shift);

    // next state and result for the bit on the input
    always_comb
    begin
        phase_next           = phase_reg;
        held_bit_next        = held_bit_reg;
        prefix_value_next    = prefix_value_reg;
        prefix_bits_next     = prefix_bits_reg;
        run_value_next       = run_value_reg;
        value_bits_left_next = value_bits_left_reg;
        pairs_written_next   = pairs_written_reg;
        res_valid            = 1'b0;
        res                  = '0;
        len                  = '0;

        case (phase_reg)
            PH_WAIT:
            begin
                pairs_written_next = '0;
                if (plane_size != '0)
                begin
                    if (stream_bit)
                    begin
                        phase_next = PH_DATA_HI;
                    end
                    else
                    begin
                        phase_next           = PH_RLE_PREFIX;
                        prefix_value_next    = '0;
                        prefix_bits_next     = '0;
                        run_value_next       = '0;
                        value_bits_left_next = '0;
                    end
                end
            end

            PH_DATA_HI:
            begin
                held_bit_next = stream_bit;
                phase_next    = PH_DATA_LO;
            end

            PH_DATA_LO:
            begin
                if (pair == 2'b00)
                begin
                    // end of data packet
                    phase_next           = PH_RLE_PREFIX;
                    prefix_value_next    = '0;
                    prefix_bits_next     = '0;
                    run_value_next       = '0;
                    value_bits_left_next = '0;
                end
                else if (pairs_left == '0)
                begin
                    phase_next = PH_WAIT;
                end
                else
                begin
                    res_valid          = 1'b1;
                    res.start_pair     = pairs_written_reg;
                    res.run_length     = PAIR_W'(1);
                    res.pair_value     = pair;
                    res.overrun        = 1'b0;
                    res.plane_done     = (pairs_left == PAIR_W'(1));
                    pairs_written_next = pairs_written_reg + PAIR_W'(1);
                    phase_next         = res.plane_done ? PH_WAIT : PH_DATA_HI;
                end
            end

            PH_RLE_PREFIX:
            begin
                prefix_value_next = {prefix_value_reg[PV_W-2:0], stream_bit};
                prefix_bits_next  = prefix_bits_inc;
                if (!stream_bit || prefix_bits_inc >= PB_W'(MAX_PREFIX_BITS))
                begin
                    value_bits_left_next = prefix_bits_inc;
                    run_value_next       = '0;
                    phase_next           = PH_RLE_VALUE;
                end
            end

            PH_RLE_VALUE:
            begin
                run_value_next       = run_value_shift;
                value_bits_left_next = value_bits_dec;
                if (value_bits_dec == '0)
                begin
                    if (pairs_left == '0)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        // clamp a run that would pass the plane end
                        if (total > TOT_W'(pairs_left))
                        begin
                            len         = pairs_left;
                            res.overrun = 1'b1;
                        end
                        else
                        begin
                            len         = total[PAIR_W-1:0];
                            res.overrun = 1'b0;
                        end
                        res_valid          = 1'b1;
                        res.start_pair     = pairs_written_reg;
                        res.run_length     = len;
                        res.pair_value     = '0;
                        res.plane_done     = (len == pairs_left);
                        pairs_written_next = pairs_written_reg + len;
                        phase_next         = res.plane_done ? PH_WAIT : PH_DATA_HI;
                    end
                end
            end

            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_WAIT;
            held_bit_reg        <= 1'b0;
            prefix_value_reg    <= '0;
            prefix_bits_reg     <= '0;
            run_value_reg       <= '0;
            value_bits_left_reg <= '0;
            pairs_written_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            held_bit_reg        <= held_bit_next;
            prefix_value_reg    <= prefix_value_next;
            prefix_bits_reg     <= prefix_bits_next;
            run_value_reg       <= run_value_next;
            value_bits_left_reg <= value_bits_left_next;
            pairs_written_reg   <= pairs_written_next;
        end
    end

    // result valid flags: result register, then skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fire && res_valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (fire && res_valid)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_pair = out_reg.start_pair;
    assign run_length = out_reg.run_length;
    assign pair_value = out_reg.pair_value;
    assign overrun    = out_reg.overrun;
    assign plane_done = out_reg.plane_done;

`ifndef SYNTHESIS
    // skid entry only ever sits behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    // every run covers at least one pair
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.run_length != '0))
        else $error("zero-length run on output");

    // literals are single pairs and never clamped
    a_literal_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.pair_value != '0) |->
        (out_reg.run_length == PAIR_W'(1) && !out_reg.overrun))
        else $error("malformed literal beat");

    // a clamped run always closes the plane
    a_overrun_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.overrun) |-> out_reg.plane_done)
        else $error("overrun without plane_done");
`endif

endmodule

`default_nettype wire
